FILE: sv/lcg_pkg.sv
// shared constants, register indexes and cosine table function for the chirp generator
package lcg_pkg;

    // default widths
    localparam int LCG_COUNT_BITS  = 17;
    localparam int LCG_PHASE_BITS  = 32;
    localparam int LCG_TABLE_BITS  = 10;
    localparam int LCG_SAMPLE_BITS = 16;

    // configuration port
    localparam int LCG_CFG_DATA_BITS = 32;
    localparam int LCG_CFG_IDX_BITS  = 3;
    localparam int LCG_CNT_REG_BITS  = 17;
    localparam int LCG_AMP_BITS      = 16;
    localparam int LCG_GAIN_SHIFT    = 15;

    typedef logic [LCG_CFG_IDX_BITS-1:0] t_cfg_idx;

    localparam t_cfg_idx CFG_SAMPLE_COUNT    = 3'd0;
    localparam t_cfg_idx CFG_START_INCREMENT = 3'd1;
    localparam t_cfg_idx CFG_CHIRP_STEP      = 3'd2;
    localparam t_cfg_idx CFG_START_PHASE     = 3'd3;
    localparam t_cfg_idx CFG_AMPLITUDE       = 3'd4;

    // register reset values
    localparam int LCG_RST_COUNT     = 125000;
    localparam int LCG_RST_AMPLITUDE = 32768;

    // fixed point constants of the table build
    localparam longint LCG_ONE_Q30     = 64'sd1 << 30;
    localparam longint LCG_HALF_PI_Q30 = 64'sd1686629713;
    localparam int     LCG_TAYLOR_N    = 11;

    // signed division truncating toward zero, shift and subtract, table build only
    function automatic longint div_trunc(input longint num, input longint den);
        logic [63:0] n_mag;
        logic [63:0] d_mag;
        logic [63:0] quo;
        logic [63:0] rem;
        logic        neg;
        neg   = (num < 0) ^ (den < 0);
        n_mag = (num < 0) ? 64'(-num) : 64'(num);
        d_mag = (den < 0) ? 64'(-den) : 64'(den);
        quo   = '0;
        rem   = '0;
        for (int b = 63; b >= 0; b--) begin
            rem = {rem[62:0], n_mag[b]};
            if (rem >= d_mag) begin
                rem    = rem - d_mag;
                quo[b] = 1'b1;
            end
        end
        return neg ? -longint'(quo) : longint'(quo);
    endfunction

    // one quarter-wave cosine entry, q30 taylor series, rounded and clamped to 0..fs
    function automatic longint cos_entry(input longint k, input int table_bits,
                                         input longint fs);
        longint x;
        longint x2;
        longint r;
        longint v;
        longint quarter;
        quarter = 64'sd1 <<< table_bits;
        x  = ((LCG_HALF_PI_Q30 * k) + (quarter >>> 1)) >>> table_bits;
        x2 = (x * x) >>> 30;
        r  = LCG_ONE_Q30;
        // partial sums feeding a product stay positive, so the q30 shift truncates
        for (int n = LCG_TAYLOR_N; n >= 1; n--) begin
            r = LCG_ONE_Q30 - (div_trunc(x2 * r, longint'((2 * n - 1) * (2 * n))) >>> 30);
        end
        if (r < 0) begin
            r = 0;
        end
        v = (r * fs + (LCG_ONE_Q30 >>> 1)) >>> 30;
        if (v > fs) begin
            v = fs;
        end
        return v;
    endfunction

endpackage

FILE: sv/linear_chirp_generator_top.sv
// linear fm chirp generator: phase accumulator with ramped increment, cosine rom, gain
// four register stages, a request is accepted into stage 1 and its sample leaves from the
// stage 4 output register; throughput: one request per cycle, an output stall holds all
// reset: synchronous active low, clears pipeline valids and sweep state, loads register
// defaults (count 125000, amplitude full scale, others zero); the cosine rom is constant
module linear_chirp_generator_top
    import lcg_pkg::*;
#(
    parameter int COUNT_BITS  = LCG_COUNT_BITS,
    parameter int PHASE_BITS  = LCG_PHASE_BITS,
    parameter int TABLE_BITS  = LCG_TABLE_BITS,
    parameter int SAMPLE_BITS = LCG_SAMPLE_BITS
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // configuration writes
    input  logic                         i_cfg_wr,
    input  logic [LCG_CFG_IDX_BITS-1:0]  i_cfg_idx,
    input  logic [LCG_CFG_DATA_BITS-1:0] i_cfg_data,
    // request channel
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic                         i_restart,
    // sample channel
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic signed [SAMPLE_BITS-1:0] o_sample,
    output logic                         o_sweep_end,
    output logic                         o_bad_count
);

    localparam int  CW      = (COUNT_BITS < LCG_CNT_REG_BITS) ? COUNT_BITS : LCG_CNT_REG_BITS;
    localparam int  MW      = SAMPLE_BITS - 1;
    localparam int  AW      = TABLE_BITS + 1;
    localparam int  QUARTER = 1 << TABLE_BITS;
    localparam int  PW      = MW + LCG_AMP_BITS;
    localparam int  SW      = PW - LCG_GAIN_SHIFT;
    localparam longint FULL_SCALE = (64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1;

    typedef logic [MW-1:0] t_rom [0:QUARTER];

    function automatic t_rom build_rom();
        t_rom rom;
        for (int k = 0; k <= QUARTER; k++) begin
            rom[k] = MW'(cos_entry(longint'(k), TABLE_BITS, FULL_SCALE));
        end
        return rom;
    endfunction

    localparam t_rom COS_ROM = build_rom();

    // configuration registers
    logic [CW-1:0]           r_sample_count;
    logic [PHASE_BITS-1:0]   r_start_inc;
    logic [PHASE_BITS-1:0]   r_chirp_step;
    logic [PHASE_BITS-1:0]   r_start_phase;
    logic [LCG_AMP_BITS-1:0] r_amplitude;

    // sweep state
    logic [COUNT_BITS-1:0]   r_index;
    logic [PHASE_BITS-1:0]   r_phase;
    logic [PHASE_BITS-1:0]   r_inc;
    logic [COUNT_BITS-1:0]   n_index;
    logic [PHASE_BITS-1:0]   n_phase;
    logic [PHASE_BITS-1:0]   n_inc;

    // pipeline registers
    logic            r_s1_valid, r_s1_bad, r_s1_last, r_s1_neg;
    logic [AW-1:0]   r_s1_addr;
    logic            r_s2_valid, r_s2_bad, r_s2_last, r_s2_neg;
    logic [MW-1:0]   r_s2_mag;
    logic            r_s3_valid, r_s3_bad, r_s3_last, r_s3_neg;
    logic [PW-1:0]   r_s3_prod;
    logic            r_s4_valid;
    logic signed [SAMPLE_BITS-1:0] r_s4_sample;
    logic            r_s4_last, r_s4_bad;

    logic            w_adv1, w_adv2, w_adv3, w_adv4;
    logic            w_accept;
    logic [COUNT_BITS-1:0] w_idx0;
    logic            w_bad, w_first, w_last, w_neg;
    logic [PHASE_BITS-1:0] w_phase;
    logic [PHASE_BITS-1:0] w_inc;
    logic [1:0]      w_quad;
    logic [TABLE_BITS-1:0] w_a;
    logic [AW-1:0]   w_addr;
    logic [SW-1:0]   w_shifted;
    logic [MW-1:0]   w_sat;
    logic signed [SAMPLE_BITS-1:0] w_sample;

    // stall chain, each stage moves when it is empty or the next one moves
    assign w_adv4   = !r_s4_valid || !i_out_stall;
    assign w_adv3   = !r_s3_valid || w_adv4;
    assign w_adv2   = !r_s2_valid || w_adv3;
    assign w_adv1   = !r_s1_valid || w_adv2;
    assign o_in_stall = !w_adv1;
    assign w_accept = i_in_valid && w_adv1;

    // configuration write port
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sample_count <= CW'(LCG_RST_COUNT);
            r_start_inc    <= '0;
            r_chirp_step   <= '0;
            r_start_phase  <= '0;
            r_amplitude    <= LCG_AMP_BITS'(LCG_RST_AMPLITUDE);
        end else if (i_cfg_wr) begin
            case (i_cfg_idx)
                CFG_SAMPLE_COUNT:    r_sample_count <= i_cfg_data[CW-1:0];
                CFG_START_INCREMENT: r_start_inc    <= PHASE_BITS'(i_cfg_data);
                CFG_CHIRP_STEP:      r_chirp_step   <= PHASE_BITS'($signed(i_cfg_data));
                CFG_START_PHASE:     r_start_phase  <= PHASE_BITS'(i_cfg_data);
                CFG_AMPLITUDE:       r_amplitude    <= i_cfg_data[LCG_AMP_BITS-1:0];
                default: ;
            endcase
        end
    end

    // sweep position, phase and increment for the incoming request
    always_comb begin
        w_idx0  = i_restart ? '0 : r_index;
        w_bad   = (r_sample_count == '0);
        w_first = (w_idx0 == '0);
        w_phase = w_first ? r_start_phase : r_phase;
        w_inc   = w_first ? r_start_inc : r_inc;
        w_last  = ((COUNT_BITS+1)'(w_idx0) + (COUNT_BITS+1)'(1))
                  >= (COUNT_BITS+1)'(r_sample_count);
        if (w_bad) begin
            n_index = '0;
            n_phase = r_phase;
            n_inc   = r_inc;
        end else begin
            n_index = w_last ? '0 : w_idx0 + COUNT_BITS'(1);
            n_phase = w_phase + w_inc;
            n_inc   = w_inc + r_chirp_step;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_index <= '0;
            r_phase <= '0;
            r_inc   <= '0;
        end else if (w_accept) begin
            r_index <= n_index;
            r_phase <= n_phase;
            r_inc   <= n_inc;
        end
    end

    // quadrant fold onto the quarter-wave table
    assign w_quad = w_phase[PHASE_BITS-1 -: 2];
    assign w_a    = w_phase[PHASE_BITS-3 -: TABLE_BITS];
    assign w_addr = w_quad[0] ? (AW'(QUARTER) - AW'(w_a)) : AW'(w_a);
    assign w_neg  = w_quad[0] ^ w_quad[1];

    // stage 1: table address and flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_adv1) begin
            r_s1_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv1) begin
            r_s1_bad  <= w_bad;
            r_s1_last <= w_last && !w_bad;
            r_s1_neg  <= w_neg;
            r_s1_addr <= w_addr;
        end
    end

    // stage 2: registered rom read
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (w_adv2) begin
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv2) begin
            r_s2_bad  <= r_s1_bad;
            r_s2_last <= r_s1_last;
            r_s2_neg  <= r_s1_neg;
            r_s2_mag  <= COS_ROM[r_s1_addr];
        end
    end

    // stage 3: gain multiply
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_valid <= 1'b0;
        end else if (w_adv3) begin
            r_s3_valid <= r_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv3) begin
            r_s3_bad  <= r_s2_bad;
            r_s3_last <= r_s2_last;
            r_s3_neg  <= r_s2_neg;
            r_s3_prod <= PW'(r_s2_mag) * PW'(r_amplitude);
        end
    end

    // q1.15 scaling, saturation and sign
    always_comb begin
        w_shifted = r_s3_prod[PW-1:LCG_GAIN_SHIFT];
        w_sat     = (SW'(FULL_SCALE) < w_shifted) ? MW'(FULL_SCALE) : w_shifted[MW-1:0];
        if (r_s3_bad) begin
            w_sample = '0;
        end else if (r_s3_neg) begin
            w_sample = -$signed({1'b0, w_sat});
        end else begin
            w_sample = $signed({1'b0, w_sat});
        end
    end

    // stage 4: output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s4_valid <= 1'b0;
        end else if (w_adv4) begin
            r_s4_valid <= r_s3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv4) begin
            r_s4_sample <= w_sample;
            r_s4_last   <= r_s3_last;
            r_s4_bad    <= r_s3_bad;
        end
    end

    assign o_out_valid = r_s4_valid;
    assign o_sample    = r_s4_sample;
    assign o_sweep_end = r_s4_last;
    assign o_bad_count = r_s4_bad;

    // a bad count sample is zero and never ends a sweep
    a_bad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_bad_count) |-> (o_sample == '0 && !o_sweep_end))
        else $error("bad count sample not zero");

    // saturation keeps the most negative code out
    a_sym_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_sample != {1'b1, {(SAMPLE_BITS-1){1'b0}}}))
        else $error("sample outside symmetric range");

    // an accepted request always lands in the first stage
    a_accept_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> r_s1_valid)
        else $error("accepted request lost");

    // the input side only stalls when every pipeline stage is full
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_s1_valid && r_s2_valid && r_s3_valid && r_s4_valid))
        else $error("input stalled with room in the pipeline");

    // a flagged sweep end restarts the sweep position
    a_end_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_last) |=> (r_index == '0))
        else $error("sweep position not cleared after last sample");

endmodule
